FILE: hw/rtl/ddo_pkg.sv
package ddo_pkg;

    // Defaults and fixed datapath widths
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int MA_W             = 38;   // multiplier operand a, signed
    localparam int MB_W             = 33;   // multiplier operand b, signed
    localparam int MP_W             = MA_W + MB_W;
    localparam int XY_W             = 44;   // rotator x / y
    localparam int Z_W              = 33;   // rotator residual angle

    typedef logic signed [MP_W-1:0] prod_t;

    localparam logic signed [MB_W-1:0] TWO_PI_Q24   = 33'sd105414357;
    localparam logic signed [MB_W-1:0] RAD_UNITS    = 33'sd683565276;
    localparam logic signed [MB_W-1:0] KINV_Q30     = 33'sd652032874;
    localparam prod_t                  LIM36        = prod_t'(64'sd68719476736);
    localparam prod_t                  S32_MAX      = prod_t'(64'sd2147483647);
    localparam prod_t                  S32_MIN      = prod_t'(-64'sd2147483648);
    localparam logic [29:0]            COEF_MAX     = 30'd536870912;
    localparam logic [6:0]             DIVISOR      = 7'd60;
    // ceil(2^24 / 15): exact floor division by 15 for operands below 2^20
    localparam logic [20:0]            RECIP15      = 21'd1118482;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WB,
        ST_DIV,
        ST_CORDIC,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_DL1, OP_DL2, OP_DR1, OP_DR2, OP_COEF,
        OP_SL1, OP_SL2, OP_FL, OP_SR1, OP_SR2, OP_FR,
        OP_H1, OP_H2, OP_H3, OP_H4, OP_S, OP_K
    } op_t;

    typedef enum logic [2:0] {
        REG_SCALE_L, REG_SCALE_R, REG_INV_TW, REG_GAIN,
        REG_START_X, REG_START_Y, REG_START_H
    } cfg_reg_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic wb;
        logic cordic;
        logic finish;
        logic publish;
    } ctl_t;

    // Round half up: add half, then floor shift
    function automatic prod_t rnd_shr(input prod_t v, input int n);
        return (v + (prod_t'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input prod_t v);
        if (v > S32_MAX)
            return 32'sh7fff_ffff;
        if (v < S32_MIN)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [MA_W-1:0] clamp36(input prod_t v);
        if (v > LIM36)
            return MA_W'(LIM36);
        if (v < -LIM36)
            return MA_W'(-LIM36);
        return MA_W'(v);
    endfunction

    // Arctangent of 2^-i, 2^32 units to a full turn
    function automatic logic [29:0] atan_q32(input logic [4:0] i);
        case (i)
            5'd0:    return 30'd536870912;
            5'd1:    return 30'd316933406;
            5'd2:    return 30'd167458907;
            5'd3:    return 30'd85004756;
            5'd4:    return 30'd42667331;
            5'd5:    return 30'd21354465;
            5'd6:    return 30'd10679838;
            5'd7:    return 30'd5340245;
            5'd8:    return 30'd2670163;
            5'd9:    return 30'd1335087;
            5'd10:   return 30'd667544;
            5'd11:   return 30'd333772;
            5'd12:   return 30'd166886;
            5'd13:   return 30'd83443;
            5'd14:   return 30'd41722;
            5'd15:   return 30'd20861;
            5'd16:   return 30'd10430;
            5'd17:   return 30'd5215;
            5'd18:   return 30'd2608;
            5'd19:   return 30'd1304;
            5'd20:   return 30'd652;
            5'd21:   return 30'd326;
            5'd22:   return 30'd163;
            5'd23:   return 30'd81;
            default: return 30'd0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/ddo_mul.sv
module ddo_mul (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [ddo_pkg::MA_W-1:0] a,
    input  logic signed [ddo_pkg::MB_W-1:0] b,
    output ddo_pkg::prod_t                 p
);
    import ddo_pkg::*;

    prod_t p_reg;

    // Shared signed multiplier, product registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= prod_t'(a) * prod_t'(b);
        end
    end

    assign p = p_reg;

endmodule

FILE: hw/rtl/ddo_div60.sv
module ddo_div60 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    output logic               done,
    output logic signed [63:0] quotient
);
    import ddo_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] mag_reg, mag_next;
    logic [5:0]  rem_reg, rem_next;
    logic        neg_reg;
    logic [63:0] abs_w;
    logic [21:0] num_w;
    logic [39:0] recip_w;
    logic [15:0] qd_w;
    logic [21:0] back_w;

    assign abs_w = dividend[63] ? 64'(-dividend) : 64'(dividend);

    // One 16-bit quotient digit per cycle; floor(n / 60) = floor(floor(n / 4) / 15)
    assign num_w   = {rem_reg, mag_reg[63:48]};
    assign recip_w = 40'(num_w[21:2]) * 40'(RECIP15);
    assign qd_w    = recip_w[39:24];
    assign back_w  = 22'(qd_w) * 22'(DIVISOR);

    // Magnitude divided, sign restored: truncation towards zero
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd4;
            mag_next  = abs_w;
            rem_next  = 6'd0;
        end
        else if (busy_reg && cnt_reg != 3'd0)
        begin
            cnt_next = cnt_reg - 3'd1;
            mag_next = {mag_reg[47:0], qd_w};
            rem_next = 6'(num_w - back_w);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        if (start)
        begin
            neg_reg <= dividend[63];
        end
    end

    assign done     = busy_reg && (cnt_reg == 3'd0);
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

FILE: hw/rtl/differential_drive_odometry_top.sv
// Differential-drive odometry: wheel readings in, pose and filtered speeds out.
// Input channel in_valid/in_ready carries one word: command, revs_left/right,
// rpm_left/right and time_step. Output channel out_valid/out_ready carries
// pos_x, pos_y, heading, speed, speed_left and speed_right, one word for each
// input word. The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per handshake; write it only when idle.
// An update word runs seventeen products on one shared multiplier, each an issue
// and a write-back state, two divisions by 60 for the rpm path (four 16-bit
// digits plus a done step each) and CORDIC_STEPS rotator steps, then updates
// the pose and publishes; out_valid is registered from the publish state. A
// restart word goes from the idle state straight to the publish state.
// in_ready is high only while the sequencer is idle, so a new word is taken
// only once the previous result has moved into the output register. If the
// receiver stalls, the finished result holds in the output register, and the
// next result waits in its final state until that register frees up.
// Reset brings the registers to their defaults (unit scales and gains, zero
// start pose) and clears the pose, heading, distances and filtered speeds.
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] revs_left,
    input  logic signed [31:0] revs_right,
    input  logic signed [23:0] rpm_left,
    input  logic signed [23:0] rpm_right,
    input  logic [19:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [15:0] heading,
    output logic signed [31:0] speed,
    output logic signed [31:0] speed_left,
    output logic signed [31:0] speed_right
);
    import ddo_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] I_LAST = IW'(CORDIC_STEPS - 1);

    // Sequencer
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    ctl_t   ctl;

    // Configuration registers
    logic [31:0]        scale_l_reg, scale_r_reg, inv_tw_reg, gain_reg;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic [15:0]        start_h_reg;

    // Pose and wheel state
    logic signed [31:0] dist_l_reg, dist_r_reg, vel_l_reg, vel_r_reg;
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic [15:0]        head_reg;

    // Latched readings and scratch
    logic signed [31:0]     revs_l_reg, revs_r_reg;
    logic signed [23:0]     rpm_l_reg, rpm_r_reg;
    logic [19:0]            dt_reg;
    logic signed [MA_W-1:0] tmp_m_reg;
    logic signed [31:0]     nl_reg, raw_reg;
    logic signed [33:0]     diff_reg;
    logic [29:0]            coef_reg;
    logic signed [51:0]     hacc_reg;
    logic signed [44:0]     rad_reg;
    logic [47:0]            uacc_reg;
    logic signed [33:0]     s_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [IW-1:0]          i_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, speed_o_reg, speed_l_reg, speed_r_reg;
    logic [15:0]        head_o_reg;

    // Shared units
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    prod_t                  mul_p;
    logic                   div_start, div_done;
    logic signed [63:0]     div_q;

    // Datapath helpers
    prod_t                  rs16, rs20, rs22, rs24;
    logic signed [31:0]     nr_w, speed_w;
    logic signed [32:0]     vsum, fdiff_l, fdiff_r;
    logic [47:0]            sum48;
    logic                   flip;
    logic [31:0]            ang_w;
    logic signed [33:0]     s_eff;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at_w;

    assign rs16    = rnd_shr(mul_p, 16);
    assign rs20    = rnd_shr(mul_p, 20);
    assign rs22    = rnd_shr(mul_p, 22);
    assign rs24    = rnd_shr(mul_p, 24);
    assign nr_w    = sat32(rs24);
    assign vsum    = 33'(vel_l_reg) + 33'(vel_r_reg);
    assign speed_w = 32'(vsum >>> 1);
    assign fdiff_l = 33'(raw_reg) - 33'(vel_l_reg);
    assign fdiff_r = 33'(raw_reg) - 33'(vel_r_reg);
    assign sum48   = uacc_reg + {mul_p[23:0], 24'h0} + 48'h0000_8000_0000;

    // Fold the left half-plane onto the right by negating the distance
    assign flip  = head_reg[15] ^ head_reg[14];
    assign ang_w = flip ? {~head_reg[15], head_reg[14:0], 16'h0} : {head_reg, 16'h0};
    assign s_eff = flip ? -s_reg : s_reg;

    assign xs   = x_reg >>> i_reg;
    assign ys   = y_reg >>> i_reg;
    assign at_w = $signed({3'b000, atan_q32(5'(i_reg))});

    ddo_mul u_mul (
        .clk (clk),
        .en  (ctl.issue),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ddo_div60 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_p[63:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = command ? ST_DONE : ST_ISSUE;
                    op_next    = OP_DL1;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (op_reg == OP_SL2 || op_reg == OP_SR2)
                begin
                    state_next = ST_DIV;
                end
                else if (op_reg == OP_K)
                begin
                    state_next = ST_CORDIC;
                end
                else
                begin
                    state_next = ST_ISSUE;
                    op_next    = op_t'(op_reg + 5'd1);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ISSUE;
                    op_next    = op_t'(op_reg + 5'd1);
                end
            end
            ST_CORDIC:
            begin
                if (i_reg == I_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctl         = '0;
        ctl.accept  = (state_reg == ST_IDLE) && in_valid;
        ctl.issue   = (state_reg == ST_ISSUE);
        ctl.wb      = (state_reg == ST_WB);
        ctl.cordic  = (state_reg == ST_CORDIC);
        ctl.finish  = (state_reg == ST_FINISH);
        ctl.publish = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    assign div_start = ctl.wb && (op_reg == OP_SL2 || op_reg == OP_SR2);
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Multiplier operand selection per operation
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_DL1:  begin mul_a = MA_W'(revs_l_reg);        mul_b = MB_W'({1'b0, scale_l_reg}); end
            OP_DR1:  begin mul_a = MA_W'(revs_r_reg);        mul_b = MB_W'({1'b0, scale_r_reg}); end
            OP_DL2:  begin mul_a = tmp_m_reg;                mul_b = TWO_PI_Q24;                 end
            OP_DR2:  begin mul_a = tmp_m_reg;                mul_b = TWO_PI_Q24;                 end
            OP_COEF: begin mul_a = MA_W'({1'b0, dt_reg});    mul_b = MB_W'({1'b0, gain_reg});    end
            OP_SL1:  begin mul_a = MA_W'(rpm_l_reg);         mul_b = MB_W'({1'b0, scale_l_reg}); end
            OP_SR1:  begin mul_a = MA_W'(rpm_r_reg);         mul_b = MB_W'({1'b0, scale_r_reg}); end
            OP_SL2:  begin mul_a = tmp_m_reg;                mul_b = TWO_PI_Q24;                 end
            OP_SR2:  begin mul_a = tmp_m_reg;                mul_b = TWO_PI_Q24;                 end
            OP_FL:   begin mul_a = MA_W'(fdiff_l);           mul_b = MB_W'({1'b0, coef_reg});    end
            OP_FR:   begin mul_a = MA_W'(fdiff_r);           mul_b = MB_W'({1'b0, coef_reg});    end
            OP_H1:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'({1'b0, inv_tw_reg[31:16]});
            end
            OP_H2:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'({1'b0, inv_tw_reg[15:0]});
            end
            OP_H3:   begin mul_a = MA_W'({1'b0, rad_reg[23:0]}); mul_b = RAD_UNITS;          end
            OP_H4:   begin mul_a = MA_W'(rad_reg >>> 24);    mul_b = RAD_UNITS;                  end
            OP_S:    begin mul_a = MA_W'({1'b0, dt_reg});    mul_b = MB_W'(speed_w);             end
            OP_K:    begin mul_a = MA_W'(s_eff);             mul_b = KINV_Q30;                   end
            default: begin mul_a = '0;                       mul_b = '0;                         end
        endcase
    end

    // Control, configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_DL1;
            out_valid_reg <= 1'b0;
            scale_l_reg   <= 32'd16777216;
            scale_r_reg   <= 32'd16777216;
            inv_tw_reg    <= 32'd16777216;
            gain_reg      <= 32'd16777216;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            start_h_reg   <= '0;
            dist_l_reg    <= '0;
            dist_r_reg    <= '0;
            vel_l_reg     <= '0;
            vel_r_reg     <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            head_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (ctl.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SCALE_L: scale_l_reg <= cfg_data;
                    REG_SCALE_R: scale_r_reg <= cfg_data;
                    REG_INV_TW:  inv_tw_reg  <= cfg_data;
                    REG_GAIN:    gain_reg    <= cfg_data;
                    REG_START_X: start_x_reg <= cfg_data;
                    REG_START_Y: start_y_reg <= cfg_data;
                    REG_START_H: start_h_reg <= cfg_data[15:0];
                    default:     ;
                endcase
            end

            // Restart: load the start pose, drop wheel history
            if (ctl.accept && command)
            begin
                x_acc_reg  <= start_x_reg;
                y_acc_reg  <= start_y_reg;
                head_reg   <= start_h_reg;
                dist_l_reg <= '0;
                dist_r_reg <= '0;
                vel_l_reg  <= '0;
                vel_r_reg  <= '0;
            end

            if (ctl.wb)
            begin
                case (op_reg)
                    OP_DR2:
                    begin
                        dist_l_reg <= nl_reg;
                        dist_r_reg <= nr_w;
                    end
                    OP_FL:   vel_l_reg <= sat32(prod_t'(vel_l_reg) + rs24);
                    OP_FR:   vel_r_reg <= sat32(prod_t'(vel_r_reg) + rs24);
                    OP_H4:   head_reg  <= head_reg + sum48[47:32];
                    default: ;
                endcase
            end

            if (ctl.finish)
            begin
                x_acc_reg <= sat32(prod_t'(x_acc_reg) + rnd_shr(prod_t'(x_reg), 8));
                y_acc_reg <= sat32(prod_t'(y_acc_reg) + rnd_shr(prod_t'(y_reg), 8));
            end
        end
    end

    // Scratch datapath
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            revs_l_reg <= revs_left;
            revs_r_reg <= revs_right;
            rpm_l_reg  <= rpm_left;
            rpm_r_reg  <= rpm_right;
            dt_reg     <= time_step;
        end

        if (ctl.wb)
        begin
            case (op_reg)
                OP_DL1:  tmp_m_reg <= clamp36(rs24);
                OP_DR1:  tmp_m_reg <= clamp36(rs24);
                OP_SL1:  tmp_m_reg <= clamp36(rs16);
                OP_SR1:  tmp_m_reg <= clamp36(rs16);
                OP_DL2:  nl_reg    <= sat32(rs24);
                OP_DR2:  diff_reg  <= (34'(nr_w) - 34'(dist_r_reg)) - (34'(nl_reg) - 34'(dist_l_reg));
                OP_COEF: coef_reg  <= (rs20 > prod_t'(COEF_MAX)) ? COEF_MAX : 30'(rs20);
                OP_H1:   hacc_reg  <= 52'(mul_p);
                OP_H2:   rad_reg   <= 45'((prod_t'(hacc_reg) + (mul_p >>> 16)) >>> 8);
                OP_H3:   uacc_reg  <= mul_p[47:0];
                OP_S:    s_reg     <= 34'(rs20);
                OP_K:
                begin
                    x_reg <= XY_W'(rs22);
                    y_reg <= '0;
                    z_reg <= Z_W'($signed(ang_w));
                    i_reg <= '0;
                end
                default: ;
            endcase
        end

        if (div_done)
        begin
            raw_reg <= sat32(rnd_shr(prod_t'(div_q), 24));
        end

        // One rotation step per cycle, direction from the residual sign
        if (ctl.cordic)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at_w;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at_w;
            end
            i_reg <= i_reg + IW'(1);
        end

        if (ctl.publish)
        begin
            pos_x_reg   <= x_acc_reg;
            pos_y_reg   <= y_acc_reg;
            head_o_reg  <= head_reg;
            speed_o_reg <= speed_w;
            speed_l_reg <= vel_l_reg;
            speed_r_reg <= vel_r_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign heading     = head_o_reg;
    assign speed       = speed_o_reg;
    assign speed_left  = speed_l_reg;
    assign speed_right = speed_r_reg;

    // Divider only finishes while the sequencer waits for it
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside division wait");

    // Rotator index never passes the last step
    a_cordic_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cordic |-> i_reg <= I_LAST)
        else $error("rotator step index overran");

    // Restart goes straight to publishing
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && command) |=> state_reg == ST_DONE)
        else $error("restart word not published directly");

    // Pose update is followed by the publish state
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> state_reg == ST_DONE)
        else $error("pose update not followed by publish");

endmodule
